@@ hw/rtl/ncs_pkg.sv @@
// Shared types, constants and distance functions for the nearest palette color search.
`default_nettype none

package ncs_pkg;

    // Field widths
    localparam int IDX_W    = 8;
    localparam int NIB_W    = 4;
    localparam int ENTRY_W  = 3 * NIB_W;
    localparam int DIST_W   = 20;
    localparam int BYTE_W   = 8;

    // Store depth default
    localparam int PALETTE_ENTRIES_DEF = 256;

    // Channel weights
    localparam int WEIGHT_RED   = 900;
    localparam int WEIGHT_GREEN = 3481;
    localparam int WEIGHT_BLUE  = 121;

    // Item function codes
    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    // Palette write broadcast to every cell
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   index;
        logic [ENTRY_W-1:0] data;
    } wr_t;

    // Search word handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic [NIB_W-1:0]  red;
        logic [NIB_W-1:0]  green;
        logic [NIB_W-1:0]  blue;
        logic [DIST_W-1:0] lead_score;
        logic [IDX_W-1:0]  lead_entry;
    } tok_t;

    // Absolute difference of two nibbles
    function automatic logic [NIB_W-1:0] abs_diff(input logic [NIB_W-1:0] a,
                                                  input logic [NIB_W-1:0] b);
        logic [NIB_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d;
    endfunction

    // Weighted square of a nibble difference: d * d * weight, cut to DIST_W bits
    function automatic logic [DIST_W-1:0] weigh_sq(input logic [NIB_W-1:0] d,
                                                   input int weight);
        int sq;
        sq = int'(d) * int'(d) * weight;
        return sq[DIST_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/nearest_palette_color_search_top.sv @@
// Top level: palette load and query front end, row of search cells, result register.
//
//  channel | signals                                         | moves
//  --------+-------------------------------------------------+--------------------------
//  in      | in_valid, in_stall, func, entry_index, pal_*,   | load or query word
//          | query_red, query_green, query_blue              |
//  out     | out_valid, out_stall, nearest_index             | one word per query
//
// A load writes the cell that owns the entry.
// A query walks the row of PALETTE_ENTRIES-1 cells, one cell a cycle, then lands in
// the result register once that register is free.
// in_stall stays high while a query is in the row; a new word is taken while a
// finished result still waits on out_stall. The row freezes when its result cannot land.
// Reset clears every palette entry to zero at once; no clearing pass.
`default_nettype none

module nearest_palette_color_search_top #(
    parameter int PALETTE_ENTRIES = ncs_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        func,
    input  wire logic [ncs_pkg::IDX_W-1:0]   entry_index,
    input  wire logic [ncs_pkg::BYTE_W-1:0]  pal_red,
    input  wire logic [ncs_pkg::BYTE_W-1:0]  pal_green,
    input  wire logic [ncs_pkg::BYTE_W-1:0]  pal_blue,
    input  wire logic [ncs_pkg::NIB_W-1:0]   query_red,
    input  wire logic [ncs_pkg::NIB_W-1:0]   query_green,
    input  wire logic [ncs_pkg::NIB_W-1:0]   query_blue,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [ncs_pkg::IDX_W-1:0]        nearest_index
);
    import ncs_pkg::*;

    localparam int CELLS = PALETTE_ENTRIES - 1;

    logic              busy_reg;
    logic              busy_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [IDX_W-1:0]  nearest_index_reg;
    logic              in_accept;
    logic              query_accept;
    logic              advance;
    logic              land;
    wr_t               wr;
    tok_t              head_tok;
    tok_t              tok [CELLS+1];
    logic [CELLS-1:0]  chain_valid;

    assign in_accept    = in_valid && !in_stall;
    assign query_accept = in_accept && (func_t'(func) == FUNC_QUERY);

    // Broadcast a load to the cells; entry zero has no cell since no query reads it
    always_comb
    begin
        wr.en    = in_accept && (func_t'(func) == FUNC_LOAD);
        wr.index = entry_index;
        wr.data  = {pal_blue[7:4], pal_green[7:4], pal_red[7:4]};
    end

    // Inject the query word at the head of the row
    always_comb
    begin
        head_tok.valid      = query_accept;
        head_tok.red        = query_red;
        head_tok.green      = query_green;
        head_tok.blue       = query_blue;
        head_tok.lead_score = '1;
        head_tok.lead_entry = IDX_W'(1);
    end

    assign tok[0] = head_tok;

    // Row of search cells, entries 1 to the last
    for (genvar k = 1; k <= CELLS; k++)
    begin : g_cell
        ncs_cell #(
            .CELL_INDEX (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .wr      (wr),
            .tok_in  (tok[k-1]),
            .tok_out (tok[k])
        );
        assign chain_valid[k-1] = tok[k].valid;
    end

    // Land the finished word when the result register is free; otherwise freeze the row
    assign land    = tok[CELLS].valid && (!out_valid_reg || !out_stall);
    assign advance = !tok[CELLS].valid || land;

    always_comb
    begin
        busy_next = busy_reg;
        if (query_accept)
        begin
            busy_next = 1'b1;
        end
        else if (land)
        begin
            busy_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (land)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result index until taken
    always_ff @(posedge clk)
    begin
        if (land)
        begin
            nearest_index_reg <= tok[CELLS].lead_entry;
        end
    end

    assign in_stall      = busy_reg;
    assign out_valid     = out_valid_reg;
    assign nearest_index = nearest_index_reg;

    // At most one query word travels the row
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_valid))
        else $error("more than one query word in the cell row");

    // Busy exactly while a query word is in the row
    a_busy_track: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (|chain_valid))
        else $error("busy flag out of step with the cell row");

    // A result never names the transparent entry
    a_not_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (nearest_index_reg != '0))
        else $error("result names entry zero");

    // A stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(nearest_index_reg)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

@@ hw/rtl/ncs_cell.sv @@
// One search cell: holds a palette entry and updates the passing search word.
`default_nettype none

module ncs_cell #(
    parameter int CELL_INDEX = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire ncs_pkg::wr_t  wr,
    input  wire ncs_pkg::tok_t tok_in,
    output ncs_pkg::tok_t      tok_out
);
    import ncs_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic [ENTRY_W-1:0] entry_reg;
    logic               valid_reg;
    tok_t               tok_reg;
    tok_t               tok_next;
    logic [DIST_W-1:0]  score;

    // Hold the palette entry; take a load aimed at this cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (wr.en && (wr.index == MY_IDX))
        begin
            entry_reg <= wr.data;
        end
    end

    // Weigh this entry against the query and keep the better candidate
    always_comb
    begin
        score = weigh_sq(abs_diff(tok_in.red,   entry_reg[3:0]),  WEIGHT_RED)
              + weigh_sq(abs_diff(tok_in.green, entry_reg[7:4]),  WEIGHT_GREEN)
              + weigh_sq(abs_diff(tok_in.blue,  entry_reg[11:8]), WEIGHT_BLUE);
        tok_next = tok_in;
        if (score < tok_in.lead_score)
        begin
            tok_next.lead_score = score;
            tok_next.lead_entry = MY_IDX;
        end
    end

    // Advance the word valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= tok_next.valid;
        end
    end

    // Advance the word payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = valid_reg;
    end

endmodule

`default_nettype wire
